[hdl/dcd_pkg.sv]
package dcd_pkg;

    localparam int DAY_W   = 7;
    localparam int MONTH_W = 7;
    localparam int YEAR_W  = 14;
    localparam int JDN_W   = 23;
    localparam int DIFF_W  = 23;
    localparam int CFG_W   = 14;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 32;

    localparam logic signed [DIFF_W:0] DIFF_LIMIT = 24'sd3700000;

    // year / 100 as ((year >> 2) * RECIP_25) >> 16, exact for years below 16384
    localparam logic [11:0] RECIP_25   = 12'd2622;
    // value / 5 as (value * RECIP_5) >> 10, exact below 512
    localparam logic [7:0]  RECIP_5    = 8'd205;
    localparam logic [14:0] YEAR_BIAS  = 15'd4716;
    localparam logic [23:0] DAY_OFFSET = 24'd1525;

    typedef enum logic [2:0] {
        CFG_MIN_DAY   = 3'd0,
        CFG_MIN_MONTH = 3'd1,
        CFG_MIN_YEAR  = 3'd2,
        CFG_MAX_DAY   = 3'd3,
        CFG_MAX_MONTH = 3'd4,
        CFG_MAX_YEAR  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctl;

    function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] month,
                                              input logic leap);
        logic [4:0] days;
        case (month)
            7'd2:                        days = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:     days = 5'd30;
            default:                     days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

[hdl/dcd_jdn.sv]
module dcd_jdn (
    input  logic                     i_clk,
    input  dcd_pkg::t_pipe_ctl       i_ctl,
    input  logic [dcd_pkg::DAY_W-1:0]   i_day,
    input  logic [dcd_pkg::MONTH_W-1:0] i_month,
    input  logic [dcd_pkg::YEAR_W-1:0]  i_year,
    output logic                     o_valid,
    output logic [dcd_pkg::JDN_W-1:0] o_jdn
);
    import dcd_pkg::*;

    logic [DAY_W-1:0]   r_s1_day;
    logic [MONTH_W-1:0] r_s1_month;
    logic [YEAR_W-1:0]  r_s1_year;
    logic [7:0]         r_s1_cent;
    logic [23:0]        w_prod1;

    logic [11:0]        w_rem;
    logic [11:0]        w_cent_x25;
    logic               w_cent_year;
    logic               w_leap;
    logic               w_jan_feb;
    logic [7:0]         w_a;
    logic [14:0]        w_yy;
    logic [7:0]         w_k;
    logic [10:0]        w_n;
    logic [4:0]         w_len;
    logic               w_valid;

    logic               r_s2_valid;
    logic [DAY_W-1:0]   r_s2_day;
    logic [7:0]         r_s2_a;
    logic [14:0]        r_s2_yy;
    logic [7:0]         r_s2_k;
    logic [8:0]         r_s2_n4;

    logic [16:0]        w_prod3;
    logic [23:0]        w_sum;

    logic               r_s3_valid;
    logic [JDN_W-1:0]   r_s3_jdn;

    function automatic logic [11:0] year_quarter(input logic [YEAR_W-1:0] y);
        return y[YEAR_W-1:2];
    endfunction

    // stage 1: century count
    assign w_prod1 = {12'd0, year_quarter(i_year)} * {12'd0, RECIP_25};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_s1_day   <= i_day;
            r_s1_month <= i_month;
            r_s1_year  <= i_year;
            r_s1_cent  <= w_prod1[23:16];
        end
    end

    // stage 2: leap rule, month shift, validity
    assign w_cent_x25  = {4'd0, r_s1_cent} * 12'd25;
    assign w_rem       = r_s1_year[YEAR_W-1:2] - w_cent_x25;
    assign w_cent_year = (r_s1_year[1:0] == 2'd0) && (w_rem == 12'd0);
    assign w_leap      = w_cent_year ? (r_s1_cent[1:0] == 2'd0) : (r_s1_year[1:0] == 2'd0);
    assign w_jan_feb   = (r_s1_month == 7'd1) || (r_s1_month == 7'd2);
    assign w_a         = r_s1_cent - {7'd0, w_jan_feb && w_cent_year && (r_s1_year != '0)};
    assign w_yy        = {1'b0, r_s1_year} + YEAR_BIAS - {14'd0, w_jan_feb};
    assign w_k         = w_jan_feb ? ({1'b0, r_s1_month} + 8'd13)
                                   : ({1'b0, r_s1_month} + 8'd1);
    assign w_n         = ({3'd0, w_k} * 11'd12) + ({9'd0, w_yy[1:0]} * 11'd5) + 11'd10;
    assign w_len       = month_days(r_s1_month, w_leap);
    assign w_valid     = (r_s1_month >= 7'd1) && (r_s1_month <= 7'd12) && (r_s1_day != '0)
                         && (r_s1_day <= {2'd0, w_len});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_s2_valid <= w_valid;
            r_s2_day   <= r_s1_day;
            r_s2_a     <= w_a;
            r_s2_yy    <= w_yy;
            r_s2_k     <= w_k;
            r_s2_n4    <= w_n[10:2];
        end
    end

    // stage 3: day number sum
    assign w_prod3 = {8'd0, r_s2_n4} * {9'd0, RECIP_5};
    assign w_sum   = ({9'd0, r_s2_yy} * 24'd365) + {11'd0, r_s2_yy[14:2]}
                   + ({16'd0, r_s2_k} * 24'd30) + {17'd0, r_s2_day}
                   + {17'd0, w_prod3[16:10]}
                   + 24'd2 + {18'd0, r_s2_a[7:2]} - {16'd0, r_s2_a} - DAY_OFFSET;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_s3_valid <= r_s2_valid;
            r_s3_jdn   <= w_sum[JDN_W-1:0];
        end
    end

    assign o_valid = r_s3_valid;
    assign o_jdn   = r_s3_jdn;

endmodule

[hdl/date_check_and_day_difference.sv]
// Channel      Direction  Handshake                     Content
// s_axis       in         s_axis_tvalid/s_axis_tready   two dates per transaction
// m_axis       out        m_axis_tvalid/m_axis_tready   flags and day difference
// cfg          in         i_cfg_wen                     bound date registers
//
// An accepted transaction passes the three day-number stages and the output register before m_axis_tvalid.
// One transaction per cycle while m_axis_tready does not stall: three day-number stages and an output register.
// Each stage holds only while it is full and the stage after it is stalled.
// i_rst_n is synchronous: it empties the pipeline and loads the default bounds.
module date_check_and_day_difference (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year
    input  logic [dcd_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // first_valid, second_valid, first_in_range, second_in_range,
    // day_difference, zero fill
    output logic [dcd_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                           i_cfg_wen,
    input  logic [dcd_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [dcd_pkg::CFG_W-1:0]      i_cfg_data
);
    import dcd_pkg::*;

    logic [4:0]        r_min_day;
    logic [3:0]        r_min_month;
    logic [YEAR_W-1:0] r_min_year;
    logic [4:0]        r_max_day;
    logic [3:0]        r_max_month;
    logic [YEAR_W-1:0] r_max_year;

    logic r_v1, r_v2, r_v3, r_out_valid;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    t_pipe_ctl w_ctl;
    t_pipe_ctl w_free;

    logic             w_fv, w_sv;
    logic [JDN_W-1:0] w_j1, w_j2, w_lo, w_hi;

    logic              n_first_in_range, n_second_in_range;
    logic signed [DIFF_W:0] n_raw, n_diff;

    logic              r_first_valid, r_second_valid;
    logic              r_first_in_range, r_second_in_range;
    logic [DIFF_W-1:0] r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_day   <= 5'd1;
            r_min_month <= 4'd1;
            r_min_year  <= 14'd1;
            r_max_day   <= 5'd31;
            r_max_month <= 4'd12;
            r_max_year  <= 14'd9999;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_MIN_DAY:   r_min_day   <= i_cfg_data[4:0];
                CFG_MIN_MONTH: r_min_month <= i_cfg_data[3:0];
                CFG_MIN_YEAR:  r_min_year  <= i_cfg_data;
                CFG_MAX_DAY:   r_max_day   <= i_cfg_data[4:0];
                CFG_MAX_MONTH: r_max_month <= i_cfg_data[3:0];
                CFG_MAX_YEAR:  r_max_year  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_rdy4 = !r_out_valid || m_axis_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;

    assign w_ctl  = '{en1: w_rdy1, en2: w_rdy2, en3: w_rdy3};
    assign w_free = '{en1: 1'b1, en2: 1'b1, en3: 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) r_v1        <= s_axis_tvalid;
            if (w_rdy2) r_v2        <= r_v1;
            if (w_rdy3) r_v3        <= r_v2;
            if (w_rdy4) r_out_valid <= r_v3;
        end
    end

    dcd_jdn u_first (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_day   (s_axis_tdata[6:0]),
        .i_month (s_axis_tdata[13:7]),
        .i_year  (s_axis_tdata[27:14]),
        .o_valid (w_fv),
        .o_jdn   (w_j1)
    );

    dcd_jdn u_second (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_day   (s_axis_tdata[34:28]),
        .i_month (s_axis_tdata[41:35]),
        .i_year  (s_axis_tdata[55:42]),
        .o_valid (w_sv),
        .o_jdn   (w_j2)
    );

    // bound day numbers run free; the user must change bounds only while the pipeline is empty, it is not enforced
    dcd_jdn u_lower (
        .i_clk   (i_clk),
        .i_ctl   (w_free),
        .i_day   ({2'd0, r_min_day}),
        .i_month ({3'd0, r_min_month}),
        .i_year  (r_min_year),
        .o_valid (),
        .o_jdn   (w_lo)
    );

    dcd_jdn u_upper (
        .i_clk   (i_clk),
        .i_ctl   (w_free),
        .i_day   ({2'd0, r_max_day}),
        .i_month ({3'd0, r_max_month}),
        .i_year  (r_max_year),
        .o_valid (),
        .o_jdn   (w_hi)
    );

    always_comb begin
        n_first_in_range  = w_fv && (w_j1 >= w_lo) && (w_j1 <= w_hi);
        n_second_in_range = w_sv && (w_j2 >= w_lo) && (w_j2 <= w_hi);
        n_raw = $signed({1'b0, w_j2}) - $signed({1'b0, w_j1});
        if (!(w_fv && w_sv)) begin
            n_diff = '0;
        end else if (n_raw > DIFF_LIMIT) begin
            n_diff = DIFF_LIMIT;
        end else if (n_raw < -DIFF_LIMIT) begin
            n_diff = -DIFF_LIMIT;
        end else begin
            n_diff = n_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_first_valid     <= w_fv;
            r_second_valid    <= w_sv;
            r_first_in_range  <= n_first_in_range;
            r_second_in_range <= n_second_in_range;
            r_diff            <= n_diff[DIFF_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_diff, r_second_in_range, r_first_in_range,
                            r_second_valid, r_first_valid};

    a_range_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_first_in_range || r_first_valid)
                        && (!r_second_in_range || r_second_valid))
        else $error("in-range flag set on an invalid date");

    a_diff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !(r_first_valid && r_second_valid) |-> r_diff == '0)
        else $error("non-zero difference with an invalid date");

    a_diff_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed({r_diff[DIFF_W-1], r_diff}) <= DIFF_LIMIT)
                        && ($signed({r_diff[DIFF_W-1], r_diff}) >= -DIFF_LIMIT))
        else $error("difference beyond saturation limit");

    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !w_rdy4 |=> r_v3 && $stable(w_j1) && $stable(w_j2))
        else $error("last stage changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2 && !r_v3 && !r_out_valid)
        else $error("pipeline not empty after reset");

endmodule
